// ===== rtl/adaptive_decimating_capture_buffer_defines.svh =====
// Assertion macros for the capture buffer checker.
// Both macros sample on i_clk; the first is switched off while i_rst_n is low.
`ifndef ADAPTIVE_DECIMATING_CAPTURE_BUFFER_DEFINES_SVH
`define ADAPTIVE_DECIMATING_CAPTURE_BUFFER_DEFINES_SVH

// Check a property outside reset.
`define ADCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ADCB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/adcb_pkg.sv =====
// Shared types and constants of the adaptive decimating capture buffer.
// Used by the lane and the top level; depends on nothing.
`default_nettype none

package adcb_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_EXP_DEF     = 24;

    localparam int CHANNELS       = 3;
    localparam int PHASE_BITS     = 24;
    localparam int SUM_GUARD      = 24;
    localparam int IDX_BITS       = 10;
    localparam int COUNT_OUT_BITS = 11;
    localparam int EXP_OUT_BITS   = 5;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic acc_en;
        logic commit_en;
        logic clear_en;
    } t_lane_ctrl;

endpackage

`default_nettype wire

// ===== rtl/adcb_ram.sv =====
// Generic single-write, dual-read memory with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module adcb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    output logic      [WIDTH-1:0] o_rdata_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== rtl/adcb_lane.sv =====
// One channel lane: saturating partial sum, floor shift and clamp of the
// stored value, pair averaging for halving, running min and max. Uses adcb_pkg.
`default_nettype none

module adcb_lane import adcb_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int EXP_BITS    = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_lane_ctrl                    i_ctrl,
    input  wire logic        [EXP_BITS-1:0]    i_exp,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] i_even,
    input  wire logic signed [SAMPLE_BITS-1:0] i_odd,
    output logic signed      [SAMPLE_BITS-1:0] o_value,
    output logic signed      [SAMPLE_BITS-1:0] o_average,
    output logic signed      [SAMPLE_BITS-1:0] o_min_next,
    output logic signed      [SAMPLE_BITS-1:0] o_max_next
);

    localparam int SUMW = SAMPLE_BITS + SUM_GUARD;
    localparam logic signed [SUMW-1:0] SUM_MAX = {1'b0, {(SUMW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_MIN = {1'b1, {(SUMW-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SUMW-1:0] S_MAX_W = SUMW'(S_MAX);
    localparam logic signed [SUMW-1:0] S_MIN_W = SUMW'(S_MIN);

    logic signed [SUMW-1:0]        r_sum;
    logic signed [SUMW-1:0]        n_sum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic signed [SUMW:0]          sum_ext;
    logic signed [SUMW-1:0]        sum_sat;
    logic signed [SUMW-1:0]        shifted;
    logic signed [SAMPLE_BITS:0]   pair;

    // Saturate the running sum on overflow of its signed width.
    assign sum_ext = (SUMW+1)'(r_sum) + (SUMW+1)'(i_sample);
    assign sum_sat = (sum_ext[SUMW] != sum_ext[SUMW-1]) ?
                     (sum_ext[SUMW] ? SUM_MIN : SUM_MAX) : sum_ext[SUMW-1:0];

    // Arithmetic shift floors; clamp sums left over from before a halving.
    assign shifted = r_sum >>> i_exp;
    always_comb begin
        if (shifted > S_MAX_W) begin
            o_value = S_MAX;
        end else if (shifted < S_MIN_W) begin
            o_value = S_MIN;
        end else begin
            o_value = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign pair      = (SAMPLE_BITS+1)'(i_even) + (SAMPLE_BITS+1)'(i_odd);
    assign o_average = pair[SAMPLE_BITS:1];

    always_comb begin
        n_sum      = r_sum;
        o_min_next = r_min;
        o_max_next = r_max;
        priority if (i_ctrl.clear_en) begin
            n_sum      = '0;
            o_min_next = S_MAX;
            o_max_next = S_MIN;
        end else if (i_ctrl.commit_en) begin
            n_sum = '0;
            if (o_value < r_min) begin
                o_min_next = o_value;
            end
            if (o_value > r_max) begin
                o_max_next = o_value;
            end
        end else if (i_ctrl.acc_en) begin
            n_sum = sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_min <= S_MAX;
            r_max <= S_MIN;
        end else begin
            r_sum <= n_sum;
            r_min <= o_min_next;
            r_max <= o_max_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adaptive_decimating_capture_buffer.sv =====
// Top level of the adaptive decimating capture buffer: sequencer, store and
// merge of the three channel lanes. Uses adcb_pkg, adcb_lane and adcb_ram.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one command item (add,
//   clear or read). Output channel o_out_valid / i_out_ready returns exactly
//   one result item for each command: count, exponent, commit flag, running
//   min and max per channel, and the entry read back.
//   The result is registered in the finishing state S_FIN, reached after
//   the accept. A new item is accepted only once the finishing state of the
//   last one has written the store and loaded the output register.
//   An add that finds the store full first walks it once, in S_HALVE and
//   S_HWB, reading two entries and writing their average each cycle over
//   the two read ports and one write port of the store.
//   Reset (synchronous, i_rst_n low) empties the store, sets exponent, phase
//   and sums to zero and the min/max to their extreme values; the store
//   contents themselves are not swept.
//   A stalled receiver holds the result; the next item is still accepted,
//   and its finishing cycle waits until the output register is free.
`default_nettype none

module adaptive_decimating_capture_buffer import adcb_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_EXP     = MAX_EXP_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_command,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_c,
    input  wire logic [IDX_BITS-1:0]           i_read_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [COUNT_OUT_BITS-1:0]          o_stored_count,
    output logic [EXP_OUT_BITS-1:0]            o_decimation_exponent,
    output logic                               o_committed,
    output logic signed [SAMPLE_BITS-1:0]      o_minimum_a,
    output logic signed [SAMPLE_BITS-1:0]      o_minimum_b,
    output logic signed [SAMPLE_BITS-1:0]      o_minimum_c,
    output logic signed [SAMPLE_BITS-1:0]      o_maximum_a,
    output logic signed [SAMPLE_BITS-1:0]      o_maximum_b,
    output logic signed [SAMPLE_BITS-1:0]      o_maximum_c,
    output logic signed [SAMPLE_BITS-1:0]      o_read_a,
    output logic signed [SAMPLE_BITS-1:0]      o_read_b,
    output logic signed [SAMPLE_BITS-1:0]      o_read_c
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = $clog2(MAX_EXP + 1);
    localparam int HALF  = DEPTH / 2;
    localparam int HW    = $clog2(HALF);
    localparam int IXW   = (AW > IDX_BITS) ? AW : IDX_BITS;
    localparam int CMPW  = (CW > IDX_BITS) ? CW : IDX_BITS;
    localparam int WIDTH = CHANNELS * SAMPLE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HALVE,
        S_HWB,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [1:0]              r_cmd;
    logic [IDX_BITS-1:0]     r_idx;
    logic [CW-1:0]           r_count;
    logic [EW-1:0]           r_exp;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [HW-1:0]           r_hidx;
    logic                    r_hpend;
    logic [AW-1:0]           r_hwaddr;
    logic                    r_out_valid;
    logic [COUNT_OUT_BITS-1:0] r_out_count;
    logic [EXP_OUT_BITS-1:0]   r_out_exp;
    logic                      r_out_commit;
    logic signed [SAMPLE_BITS-1:0] r_out_min  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out_max  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] r_out_read [CHANNELS];

    logic [CW-1:0]         n_count;
    logic [EW-1:0]         n_exp;
    logic [PHASE_BITS-1:0] n_phase;
    logic signed [SAMPLE_BITS-1:0] n_read [CHANNELS];

    logic                  accept;
    logic                  go;
    logic                  fin_go;
    logic                  full;
    logic                  do_commit;
    logic                  rd_hit;
    logic [PHASE_BITS-1:0] phase_inc;
    logic [PHASE_BITS-1:0] emask;
    logic [IXW-1:0]        in_idx_wide;
    logic [IXW-1:0]        r_idx_wide;
    t_lane_ctrl            lane_ctrl;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WIDTH-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr_a;
    logic [AW-1:0]    ram_raddr_b;
    logic [WIDTH-1:0] ram_rdata_a;
    logic [WIDTH-1:0] ram_rdata_b;

    logic signed [SAMPLE_BITS-1:0] samples  [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] values   [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] averages [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] min_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] max_next [CHANNELS];

    assign samples[0] = i_sample_a;
    assign samples[1] = i_sample_b;
    assign samples[2] = i_sample_c;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign go         = !r_out_valid || i_out_ready;
    assign fin_go     = (r_state == S_FIN) && go;
    assign full       = (r_count == CW'(DEPTH));

    // A commit falls when the low exponent bits of the new phase are zero.
    assign phase_inc = PHASE_BITS'(r_phase + 1'b1);
    assign emask     = ~({PHASE_BITS{1'b1}} << r_exp);
    assign do_commit = ((phase_inc & emask) == '0) && (r_count < CW'(DEPTH));

    assign in_idx_wide = IXW'(i_read_index);
    assign r_idx_wide  = IXW'(r_idx);
    assign rd_hit      = (r_cmd == CMD_READ) && (CMPW'(r_idx) < CMPW'(r_count));

    assign lane_ctrl.acc_en    = accept && (i_command == CMD_ADD);
    assign lane_ctrl.commit_en = fin_go && (r_cmd == CMD_ADD) && do_commit;
    assign lane_ctrl.clear_en  = fin_go && (r_cmd == CMD_CLEAR);

    always_comb begin
        unique case (r_state)
            S_IDLE:  ram_raddr_a = in_idx_wide[AW-1:0];
            S_HALVE: ram_raddr_a = AW'({r_hidx, 1'b0});
            default: ram_raddr_a = r_idx_wide[AW-1:0];
        endcase
    end
    assign ram_raddr_b = AW'({r_hidx, 1'b1});

    // Halving write-back follows its read in the next cycle; commits use the count.
    assign ram_we    = r_hpend || lane_ctrl.commit_en;
    assign ram_waddr = r_hpend ? r_hwaddr : r_count[AW-1:0];
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            ram_wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = r_hpend ? averages[c] : values[c];
            n_read[c] = rd_hit ? ram_rdata_a[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        end
    end

    always_comb begin
        n_count = r_count;
        n_exp   = r_exp;
        n_phase = r_phase;
        unique case (r_cmd)
            CMD_ADD: begin
                n_phase = phase_inc;
                if (do_commit) begin
                    n_count = CW'(r_count + 1'b1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
                n_exp   = '0;
                n_phase = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_exp       <= '0;
            r_phase     <= '0;
            r_hidx      <= '0;
            r_hpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_command;
                        r_idx   <= i_read_index;
                        r_hidx  <= '0;
                        r_state <= (i_command == CMD_ADD && full) ? S_HALVE : S_FIN;
                    end
                end
                S_HALVE: begin
                    r_hpend  <= 1'b1;
                    r_hwaddr <= AW'(r_hidx);
                    r_hidx   <= HW'(r_hidx + 1'b1);
                    if (r_hidx == HW'(HALF - 1)) begin
                        r_state <= S_HWB;
                    end
                end
                S_HWB: begin
                    // Last pair lands now; the add then sees phase 1.
                    r_hpend <= 1'b0;
                    r_count <= CW'(HALF);
                    r_phase <= '0;
                    if (r_exp < EW'(MAX_EXP)) begin
                        r_exp <= EW'(r_exp + 1'b1);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (go) begin
                        r_count      <= n_count;
                        r_exp        <= n_exp;
                        r_phase      <= n_phase;
                        r_out_count  <= COUNT_OUT_BITS'(n_count);
                        r_out_exp    <= EXP_OUT_BITS'(n_exp);
                        r_out_commit <= lane_ctrl.commit_en;
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_out_min[c]  <= min_next[c];
                            r_out_max[c]  <= max_next[c];
                            r_out_read[c] <= n_read[c];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    adcb_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        adcb_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .EXP_BITS    (EW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (lane_ctrl),
            .i_exp      (r_exp),
            .i_sample   (samples[g]),
            .i_even     (ram_rdata_a[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_odd      (ram_rdata_b[g*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_value    (values[g]),
            .o_average  (averages[g]),
            .o_min_next (min_next[g]),
            .o_max_next (max_next[g])
        );
    end

    assign o_out_valid           = r_out_valid;
    assign o_stored_count        = r_out_count;
    assign o_decimation_exponent = r_out_exp;
    assign o_committed           = r_out_commit;
    assign o_minimum_a           = r_out_min[0];
    assign o_minimum_b           = r_out_min[1];
    assign o_minimum_c           = r_out_min[2];
    assign o_maximum_a           = r_out_max[0];
    assign o_maximum_b           = r_out_max[1];
    assign o_maximum_c           = r_out_max[2];
    assign o_read_a              = r_out_read[0];
    assign o_read_b              = r_out_read[1];
    assign o_read_c              = r_out_read[2];

endmodule

`default_nettype wire

// ===== rtl/adcb_checker.sv =====
// Port-level checker for the capture buffer, bound to the top level.
// Uses the assertion macros of adaptive_decimating_capture_buffer_defines.svh.
`default_nettype none
`include "adaptive_decimating_capture_buffer_defines.svh"

module adcb_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_EXP     = 24
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [10:0]                   o_stored_count,
    input wire logic [4:0]                    o_decimation_exponent,
    input wire logic                          o_committed,
    input wire logic signed [SAMPLE_BITS-1:0] o_minimum_a,
    input wire logic signed [SAMPLE_BITS-1:0] o_minimum_b,
    input wire logic signed [SAMPLE_BITS-1:0] o_minimum_c,
    input wire logic signed [SAMPLE_BITS-1:0] o_maximum_a,
    input wire logic signed [SAMPLE_BITS-1:0] o_maximum_b,
    input wire logic signed [SAMPLE_BITS-1:0] o_maximum_c
);

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A held result keeps its status fields.
    `ADCB_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_stored_count) && $stable(o_committed) && $stable(o_minimum_a), "result item changed while stalled")

    `ADCB_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result item present after reset")

    // One item at a time: input closes after each accept.
    `ADCB_ASSERT(a_one_item, i_in_valid && o_in_ready |=> !o_in_ready, "input still open after an accepted item")

    `ADCB_ASSERT(a_exp_bound, o_out_valid |-> o_decimation_exponent <= MAX_EXP, "exponent beyond its limit")

    // Either nothing stored since clear, or min never above max.
    `ADCB_ASSERT(a_min_max, o_out_valid |-> ((o_minimum_a <= o_maximum_a) || (o_minimum_a == S_MAX && o_maximum_a == S_MIN)) && ((o_minimum_b <= o_maximum_b) || (o_minimum_b == S_MAX && o_maximum_b == S_MIN)) && ((o_minimum_c <= o_maximum_c) || (o_minimum_c == S_MAX && o_maximum_c == S_MIN)), "running min above running max")

endmodule

bind adaptive_decimating_capture_buffer adcb_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_EXP     (MAX_EXP)
) u_adcb_checker (.*);

`default_nettype wire
